### hdl/cdq_pkg.sv
// Shared types and constants for the circular deque core.
// No dependencies; compile first.
`default_nettype none

package cdq_pkg;

	// Queue capacity in entries
	localparam int unsigned DEPTH = 8;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		FUNC_PUSH_FRONT = 2'd0,
		FUNC_PUSH_REAR  = 2'd1,
		FUNC_POP_FRONT  = 2'd2,
		FUNC_POP_REAR   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_HOLD       = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_PUSH_REAR  = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_POP_REAR   = 3'd4
	} cell_cmd_t;

	// What one cell shows its neighbors
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] data;
	} cell_link_t;

endpackage

`default_nettype wire

### hdl/cdq_ifs.sv
// Request and response channel interfaces of the circular deque core.
// Depends on cdq_pkg.
`default_nettype none

interface cdq_req_if import cdq_pkg::*; ();
	logic               valid;
	logic               ready;
	func_t              func;
	logic signed [31:0] push_value;

	modport source (output valid, func, push_value, input ready);
	modport sink (input valid, func, push_value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] pop_value;
	status_t            status;

	modport source (output valid, pop_value, status, input ready);
	modport sink (input valid, pop_value, status, output ready);
endinterface

`default_nettype wire

### hdl/cdq_cell.sv
// One storage cell of the deque shift chain: holds one value and its valid bit.
// Depends on cdq_pkg.
`default_nettype none

module cdq_cell
	import cdq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_cmd_t         cmd,
	input  wire logic [DATA_W-1:0] push_value,
	input  wire cell_link_t        left,
	input  wire cell_link_t        right,
	output cell_link_t             cur,
	output logic      [DATA_W-1:0] tap
);

	logic              valid_q;
	logic [DATA_W-1:0] data_q;
	logic              is_last;
	cell_link_t        nxt;

	assign is_last = valid_q && !right.valid;
	assign cur     = '{valid: valid_q, data: data_q};
	assign tap     = is_last ? data_q : '0;

	always_comb begin
		nxt = cur;
		unique case (cmd)
			CMD_HOLD: begin
				nxt = cur;
			end
			CMD_PUSH_FRONT: begin
				nxt = left;
			end
			CMD_PUSH_REAR: begin
				// first free cell takes the value
				if (left.valid && !valid_q) begin
					nxt = '{valid: 1'b1, data: push_value};
				end
			end
			CMD_POP_FRONT: begin
				nxt = right;
			end
			CMD_POP_REAR: begin
				if (is_last) begin
					nxt.valid = 1'b0;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt.data;
	end

endmodule

`default_nettype wire

### hdl/circular_deque_core.sv
// Circular deque core: a double-ended queue of DEPTH signed 32-bit values with
// one request and one response per operation. The queue is a packed row of
// DEPTH cells: the front value sits in cell 0 and the rear in the last valid
// cell. Push front and pop front shift the whole row by one cell; push rear
// and pop rear touch only the cell at the boundary between valid and free
// cells. Every request completes when it is accepted and its response is
// registered, so the block takes one request per clock while the response
// side keeps up; a stalled response holds further requests. Full and empty
// come from the valid bits at the two ends of the row. Pushes onto a full
// queue report overflow, pops from an empty queue report empty; both leave
// the contents unchanged and return a zero pop_value.
// Depends on cdq_pkg, cdq_ifs and cdq_cell.
`default_nettype none

module circular_deque_core
	import cdq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	cdq_req_if.sink    req,
	cdq_rsp_if.source  rsp
);

	cell_link_t        cur_lnk   [DEPTH];
	cell_link_t        left_lnk  [DEPTH];
	cell_link_t        right_lnk [DEPTH];
	logic [DATA_W-1:0] tap       [DEPTH];

	cell_cmd_t         cmd;
	logic              accept;
	logic              full;
	logic              empty;
	logic [DATA_W-1:0] rear_value;
	logic [DATA_W-1:0] res_value;
	status_t           res_status;

	logic              rsp_valid_q;
	logic [DATA_W-1:0] pop_value_q;
	status_t           status_q;

	assign full   = cur_lnk[DEPTH-1].valid;
	assign empty  = !cur_lnk[0].valid;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	// neighbor wiring: the row is open at both ends
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0) begin
				left_lnk[i] = '{valid: 1'b1, data: req.push_value};
			end else begin
				left_lnk[i] = cur_lnk[i-1];
			end
			if (i == DEPTH - 1) begin
				right_lnk[i] = '{valid: 1'b0, data: '0};
			end else begin
				right_lnk[i] = cur_lnk[i+1];
			end
		end
	end

	// only the last valid cell drives its tap
	always_comb begin
		rear_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_value = rear_value | tap[i];
		end
	end

	always_comb begin
		cmd        = CMD_HOLD;
		res_value  = '0;
		res_status = ST_DONE;
		unique case (req.func)
			FUNC_PUSH_FRONT: begin
				if (full) begin
					res_status = ST_OVERFLOW;
				end else begin
					cmd = CMD_PUSH_FRONT;
				end
			end
			FUNC_PUSH_REAR: begin
				if (full) begin
					res_status = ST_OVERFLOW;
				end else begin
					cmd = CMD_PUSH_REAR;
				end
			end
			FUNC_POP_FRONT: begin
				if (empty) begin
					res_status = ST_EMPTY;
				end else begin
					cmd       = CMD_POP_FRONT;
					res_value = cur_lnk[0].data;
				end
			end
			FUNC_POP_REAR: begin
				if (empty) begin
					res_status = ST_EMPTY;
				end else begin
					cmd       = CMD_POP_REAR;
					res_value = rear_value;
				end
			end
			default: begin
				cmd = CMD_HOLD;
			end
		endcase
		// hold the row unless a request is taken
		if (!accept) begin
			cmd = CMD_HOLD;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		cdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.push_value (req.push_value),
			.left       (left_lnk[g]),
			.right      (right_lnk[g]),
			.cur        (cur_lnk[g]),
			.tap        (tap[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_value_q <= res_value;
			status_q    <= res_status;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.pop_value = pop_value_q;
	assign rsp.status    = status_q;

endmodule

`default_nettype wire

### test/tb_circular_deque_core.sv
// Testbench for circular_deque_core: directed and random push/pop requests with
// a ring-buffer mirror predicting every response. Needs cdq_pkg, cdq_ifs and the core.
`timescale 1ns / 100ps

module tb_circular_deque_core;
	import cdq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct {
		logic signed [31:0] pop_value;
		status_t            status;
	} deque_rsp_t;

	// Mirror of the deque: ring storage, indices and fill level
	class deque_mirror;
		logic signed [31:0] ring [DEPTH];
		int unsigned        head_idx;
		int unsigned        tail_idx;
		int unsigned        fill;
		deque_rsp_t         expected_rsps[$];
		int                 errors;

		function new();
			head_idx = 0;
			tail_idx = 0;
			fill = 0;
			errors = 0;
		endfunction

		function void note_request(func_t op, logic signed [31:0] value);
			deque_rsp_t rsp_item;
			rsp_item.pop_value = '0;
			rsp_item.status = ST_DONE;
			case (op)
				FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
					if (fill >= DEPTH) begin
						rsp_item.status = ST_OVERFLOW;
					end else if (op == FUNC_PUSH_FRONT) begin
						head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
						ring[head_idx] = value;
						fill++;
					end else begin
						ring[tail_idx] = value;
						tail_idx = (tail_idx + 1 >= DEPTH) ? 0 : tail_idx + 1;
						fill++;
					end
				end
				default: begin
					if (fill == 0) begin
						rsp_item.status = ST_EMPTY;
					end else if (op == FUNC_POP_FRONT) begin
						rsp_item.pop_value = ring[head_idx];
						head_idx = (head_idx + 1 >= DEPTH) ? 0 : head_idx + 1;
						fill--;
					end else begin
						tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
						rsp_item.pop_value = ring[tail_idx];
						fill--;
					end
				end
			endcase
			expected_rsps.push_back(rsp_item);
		endfunction

		function void check_response(logic signed [31:0] pop_value, status_t status);
			deque_rsp_t exp_item;
			if (expected_rsps.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected response: pop_value=%0d status=%s",
						pop_value, status.name());
				return;
			end
			exp_item = expected_rsps.pop_front();
			if (pop_value !== exp_item.pop_value || status !== exp_item.status) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch: expected pop_value=%0d status=%s, got pop_value=%0d status=%s",
						exp_item.pop_value, exp_item.status.name(), pop_value, status.name());
			end
		endfunction

		function int pending();
			return expected_rsps.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int unsigned cycles;

	cdq_req_if req_ch ();
	cdq_rsp_if rsp_ch ();

	deque_mirror deque_ref;

	circular_deque_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_PUSH_FRONT;
		req_ch.push_value = '0;
		rsp_ch.ready = 1'b0;
		calm = 1'b0;
		cycles = 0;
		deque_ref = new();
	end

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Call at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input func_t op, input logic signed [31:0] value);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.func = op;
		req_ch.push_value = value;
		do @(posedge clk); while (!req_ch.ready);
		deque_ref.note_request(op, value);
		@(negedge clk);
	endtask

	// Hold off new requests until the block has answered everything
	task automatic drain_responses();
		req_ch.valid = 1'b0;
		while (deque_ref.pending() != 0) @(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(input int unsigned push_pct, input int unsigned count);
		func_t op;
		repeat (count) begin
			if ($urandom_range(0, 99) < push_pct)
				op = $urandom_range(0, 1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT;
			else
				op = $urandom_range(0, 1) ? FUNC_POP_REAR : FUNC_POP_FRONT;
			send_request(op, pick_value());
		end
	endtask

	// Response side: random stall per response, then check at acceptance
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			deque_ref.check_response(rsp_ch.pop_value, rsp_ch.status);
			@(negedge clk);
		end
	end

	initial begin
		int unsigned push_pct;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Pops on the empty queue, then fill with extremes, wrapping the front
		send_request(FUNC_POP_FRONT, 32'sd5);
		send_request(FUNC_POP_REAR, -32'sd5);
		send_request(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF);
		send_request(FUNC_PUSH_REAR, 32'sh8000_0000);
		send_request(FUNC_PUSH_FRONT, -32'sd1);
		send_request(FUNC_PUSH_REAR, 32'sd0);
		send_request(FUNC_PUSH_REAR, 32'sh5555_5555);
		send_request(FUNC_PUSH_FRONT, 32'shAAAA_AAAA);
		send_request(FUNC_PUSH_REAR, 32'sd1);
		send_request(FUNC_PUSH_FRONT, -32'sd2);
		// Full: both pushes overflow
		send_request(FUNC_PUSH_FRONT, 32'sd77);
		send_request(FUNC_PUSH_REAR, -32'sd77);
		repeat (4) send_request(FUNC_POP_FRONT, 32'sd0);
		repeat (4) send_request(FUNC_POP_REAR, -32'sd1);
		send_request(FUNC_POP_FRONT, 32'sd0);
		send_request(FUNC_POP_REAR, 32'sd0);
		drain_responses();

		for (int phase = 0; phase < 12; phase++) begin
			case ($urandom_range(0, 4))
				0: push_pct = 80;
				1: push_pct = 20;
				2: push_pct = 65;
				3: push_pct = 35;
				default: push_pct = 50;
			endcase
			calm = ($urandom_range(0, 3) == 0);
			run_phase(push_pct, 150);
			if (phase == 2 || $urandom_range(0, 3) == 0)
				drain_responses();
		end
		calm = 1'b0;

		req_ch.valid = 1'b0;
		while (deque_ref.pending() != 0) @(negedge clk);
		repeat (5) @(posedge clk);
		if (deque_ref.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
hdl/cdq_pkg.sv
hdl/cdq_ifs.sv
hdl/cdq_cell.sv
hdl/circular_deque_core.sv
test/tb_circular_deque_core.sv
